// ----- hdl/jetp_pkg.sv -----
// Shared types, constants and helpers for the Julia escape-time pixel engine.
// Depends on nothing; jetp_front, jetp_back and the top level use scoped names.
`default_nettype none

package jetp_pkg;

	// Q5.27 fixed point, the same format as the c registers.
	localparam int FRAC_BITS = 27;
	localparam int WORD_W = FRAC_BITS + 5;
	// Spans of the window are below 4.0, so they need two integer bits.
	localparam int SPAN_W = FRAC_BITS + 2;
	// Floored square, floored cross term, and the widened sum for saturation.
	localparam int SQ_W = 2 * WORD_W - FRAC_BITS;
	localparam int XP_W = SQ_W + 1;
	localparam int EXT_W = SQ_W + 2;
	localparam int SUM_W = SQ_W + 1;

	localparam int DIM_W = 13;
	localparam int ITER_W = 16;
	localparam int CREG_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Window constants, rounded to nearest.
	localparam longint XSPAN_L = ((longint'(32) <<< FRAC_BITS) + 5) / 10;
	localparam longint XMIN_L = ((longint'(16) <<< FRAC_BITS) + 5) / 10;
	localparam longint YSPAN_L = ((longint'(18) <<< FRAC_BITS) + 5) / 10;
	localparam longint YMIN_L = ((longint'(9) <<< FRAC_BITS) + 5) / 10;

	localparam logic [SPAN_W-1:0] XSPAN_FX = SPAN_W'(XSPAN_L);
	localparam logic [SPAN_W-1:0] YSPAN_FX = SPAN_W'(YSPAN_L);
	localparam logic [WORD_W-1:0] XMIN_FX = WORD_W'(-XMIN_L);
	localparam logic [WORD_W-1:0] YMIN_FX = WORD_W'(-YMIN_L);
	localparam logic [SUM_W-1:0] ESC_LIM = SUM_W'(longint'(4) <<< FRAC_BITS);

	localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST = 13'd1024;
	localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd512;
	localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd300;
	localparam logic [CREG_W-1:0] C_REAL_RST = 32'(-106032005);
	localparam logic [CREG_W-1:0] C_IMAG_RST = 32'(20132659);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_MAX_ITER = 3'd2,
		CFG_C_REAL = 3'd3,
		CFG_C_IMAG = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_DIV,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_UPD,
		BK_DONE
	} back_state_t;

	// One classified pixel on its way from the front end to the iteration engine.
	typedef struct packed {
		logic bad;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} job_t;

	typedef struct packed {
		logic status;
		logic [ITER_W-1:0] left;
		logic in_set;
	} res_t;

	// Clamp a widened two's complement value to the iteration word.
	function automatic logic [WORD_W-1:0] sat_word(input logic [EXT_W-1:0] v);
		logic [EXT_W-WORD_W:0] top;
		top = v[EXT_W-1:WORD_W-1];
		if (top == '0 || top == '1) begin
			return v[WORD_W-1:0];
		end else if (v[EXT_W-1]) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/jetp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the pixel-to-window mapping.
// Uses no package items.
`default_nettype none

module jetp_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 13
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [NUM_W-1:0] num,
	input wire logic [DEN_W-1:0] den,
	output logic busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] trial;
	logic fits;

	// The numerator shifts out at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

endmodule

`default_nettype wire

// ----- hdl/jetp_front.sv -----
// Front end: takes a pixel, checks it against the image size and maps it onto the window.
// Depends on jetp_pkg and jetp_div.
`default_nettype none

module jetp_front #(
	parameter int COORD_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [COORD_BITS-1:0] pixel_x,
	input wire logic [COORD_BITS-1:0] pixel_y,
	input wire logic [jetp_pkg::DIM_W-1:0] image_width,
	input wire logic [jetp_pkg::DIM_W-1:0] image_height,
	output logic job_valid,
	input wire logic job_ready,
	output jetp_pkg::job_t job
);

	localparam int CMP_W = (COORD_BITS > jetp_pkg::DIM_W) ? COORD_BITS : jetp_pkg::DIM_W;
	localparam int NUM_W = jetp_pkg::SPAN_W + COORD_BITS;
	localparam int PAD_W = jetp_pkg::WORD_W - jetp_pkg::SPAN_W;

	jetp_pkg::front_state_t state_q, state_d;
	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic bad_q;
	logic out_range;
	logic div_start;
	logic [NUM_W-1:0] num_x;
	logic [NUM_W-1:0] num_y;
	logic [NUM_W-1:0] quo_x;
	logic [NUM_W-1:0] quo_y;
	logic busy_x;
	logic busy_y;

	// A zero width or height puts every pixel outside the image.
	assign out_range = (CMP_W'(pixel_x) >= CMP_W'(image_width)) ||
		(CMP_W'(pixel_y) >= CMP_W'(image_height));

	// The products load straight into the dividers' shift registers.
	assign num_x = NUM_W'(jetp_pkg::XSPAN_FX) * NUM_W'(px_q);
	assign num_y = NUM_W'(jetp_pkg::YSPAN_FX) * NUM_W'(py_q);

	jetp_div #(
		.NUM_W(NUM_W),
		.DEN_W(jetp_pkg::DIM_W)
	) u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_x),
		.den(image_width),
		.busy(busy_x),
		.quo(quo_x)
	);

	jetp_div #(
		.NUM_W(NUM_W),
		.DEN_W(jetp_pkg::DIM_W)
	) u_div_y (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_y),
		.den(image_height),
		.busy(busy_y),
		.quo(quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jetp_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == jetp_pkg::FR_IDLE && push) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
			bad_q <= out_range;
		end
	end

	always_comb begin
		state_d = state_q;
		full = 1'b1;
		div_start = 1'b0;
		job_valid = 1'b0;
		unique case (state_q)
			jetp_pkg::FR_IDLE: begin
				full = 1'b0;
				if (push) begin
					state_d = out_range ? jetp_pkg::FR_PUSH : jetp_pkg::FR_MUL;
				end
			end
			jetp_pkg::FR_MUL: begin
				div_start = 1'b1;
				state_d = jetp_pkg::FR_DIV;
			end
			jetp_pkg::FR_DIV: begin
				if (!busy_x && !busy_y) begin
					state_d = jetp_pkg::FR_PUSH;
				end
			end
			jetp_pkg::FR_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) begin
					state_d = jetp_pkg::FR_IDLE;
				end
			end
			default: state_d = jetp_pkg::FR_IDLE;
		endcase
	end

	// The quotient stays below the span because the pixel is inside the image.
	always_comb begin
		job.bad = bad_q;
		job.a = {{PAD_W{1'b0}}, quo_y[jetp_pkg::SPAN_W-1:0]} + jetp_pkg::YMIN_FX;
		job.b = {{PAD_W{1'b0}}, quo_x[jetp_pkg::SPAN_W-1:0]} + jetp_pkg::XMIN_FX;
	end

	a_job_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job.bad |-> !busy_x && !busy_y)
		else $error("front offered a mapped pixel before the dividers finished");

endmodule

`default_nettype wire

// ----- hdl/jetp_fifo.sv -----
// Small register queue that decouples the front end from the iteration engine.
// Uses no package items.
`default_nettype none

module jetp_fifo #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [WIDTH-1:0] wr_data,
	output logic full,
	input wire logic rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/jetp_back.sv -----
// Iteration engine: runs z = z*z + c for one pixel and holds the finished result.
// Depends on jetp_pkg.
`default_nettype none

module jetp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input wire jetp_pkg::job_t job,
	output logic job_pop,
	input wire logic [jetp_pkg::ITER_W-1:0] max_iterations,
	input wire logic [jetp_pkg::CREG_W-1:0] c_real,
	input wire logic [jetp_pkg::CREG_W-1:0] c_imag,
	output logic empty,
	input wire logic pop,
	output logic status,
	output logic [jetp_pkg::ITER_W-1:0] iterations_left,
	output logic in_set
);

	localparam int W = jetp_pkg::WORD_W;
	localparam int F = jetp_pkg::FRAC_BITS;
	localparam int CPAD_W = jetp_pkg::EXT_W - jetp_pkg::CREG_W;

	jetp_pkg::back_state_t state_q, state_d;
	logic signed [W-1:0] a_q;
	logic signed [W-1:0] b_q;
	logic [jetp_pkg::ITER_W-1:0] left_q;
	logic bad_q;
	logic [jetp_pkg::SQ_W-1:0] a2_s1;
	logic [jetp_pkg::SQ_W-1:0] b2_s1;
	logic [jetp_pkg::XP_W-1:0] ab_s1;
	logic signed [2*W-1:0] aa;
	logic signed [2*W-1:0] bb;
	logic signed [2*W-1:0] ab;
	logic [jetp_pkg::SUM_W-1:0] mag2;
	logic escape;
	logic [jetp_pkg::EXT_W-1:0] nb_raw;
	logic [jetp_pkg::EXT_W-1:0] na_raw;
	logic load_res;
	jetp_pkg::res_t res_q;
	logic res_valid_q;

	assign aa = a_q * a_q;
	assign bb = b_q * b_q;
	assign ab = b_q * a_q;

	// Squares are never negative, so their floored high parts are plain magnitudes.
	// The c registers already carry the word's fraction bits and need no rescaling.
	assign mag2 = {1'b0, a2_s1} + {1'b0, b2_s1};
	assign escape = mag2 >= jetp_pkg::ESC_LIM;
	assign nb_raw = {2'b00, b2_s1} - {2'b00, a2_s1} + {{CPAD_W{c_real[jetp_pkg::CREG_W-1]}}, c_real};
	assign na_raw = {ab_s1[jetp_pkg::XP_W-1], ab_s1} +
		{{CPAD_W{c_imag[jetp_pkg::CREG_W-1]}}, c_imag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jetp_pkg::BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			jetp_pkg::BK_IDLE: begin
				if (job_valid) begin
					a_q <= job.a;
					b_q <= job.b;
					bad_q <= job.bad;
					left_q <= max_iterations;
				end
			end
			jetp_pkg::BK_MUL: begin
				a2_s1 <= aa[2*W-1:F];
				b2_s1 <= bb[2*W-1:F];
				ab_s1 <= ab[2*W-1:F-1];
			end
			jetp_pkg::BK_UPD: begin
				if (!escape) begin
					a_q <= jetp_pkg::sat_word(na_raw);
					b_q <= jetp_pkg::sat_word(nb_raw);
					left_q <= left_q - jetp_pkg::ITER_W'(1);
				end
			end
			jetp_pkg::BK_DONE: begin
			end
			default: begin
			end
		endcase
		if (load_res) begin
			res_q.status <= bad_q;
			res_q.left <= bad_q ? '0 : left_q;
			res_q.in_set <= !bad_q && left_q == '0;
		end
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			jetp_pkg::BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = jetp_pkg::BK_MUL;
				end
			end
			jetp_pkg::BK_MUL: begin
				if (bad_q || left_q == '0) begin
					state_d = jetp_pkg::BK_DONE;
				end else begin
					state_d = jetp_pkg::BK_UPD;
				end
			end
			jetp_pkg::BK_UPD: begin
				state_d = escape ? jetp_pkg::BK_DONE : jetp_pkg::BK_MUL;
			end
			jetp_pkg::BK_DONE: begin
				if (!res_valid_q || pop) begin
					load_res = 1'b1;
					state_d = jetp_pkg::BK_IDLE;
				end
			end
			default: state_d = jetp_pkg::BK_IDLE;
		endcase
	end

	assign empty = !res_valid_q;
	assign status = res_q.status;
	assign iterations_left = res_q.left;
	assign in_set = res_q.in_set;

	a_in_set_no_budget: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.in_set |-> res_q.left == '0 && !res_q.status)
		else $error("in-set result carries a remaining budget or an error");

	a_upd_has_budget: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jetp_pkg::BK_UPD |-> left_q != '0)
		else $error("update step entered with no budget left");

	a_step_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jetp_pkg::BK_UPD && !escape |=>
		left_q == $past(left_q) - jetp_pkg::ITER_W'(1))
		else $error("budget not decremented after a non-escaping step");

endmodule

`default_nettype wire

// ----- hdl/julia_escape_time_pixel.sv -----
// Julia set escape-time engine for one pixel per transaction: top level.
// Holds the configuration registers; depends on jetp_pkg, jetp_front, jetp_fifo, jetp_back.
//
// Input side: a transaction is taken when push is high and full is low; pixel_x/pixel_y
// name the pixel. Result side: while empty is low the oldest result sits on status,
// iterations_left and in_set; pop with empty low takes it. Results leave in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index at that edge; indexes
// past the register list are ignored. Write only while no pixel is in flight.
// Flow: the front end checks and maps a pixel through two bit-serial dividers before the
// job enters the queue, and takes no new pixel until that job is queued. The iteration
// engine works on one pixel at a time; each step has one state for the three 32x32
// products and one for the add, escape test and saturation, and a pixel runs at most
// max_iterations steps. Pixels outside the image skip the dividers and the steps.
// Reset clears all queues and loads 1024 x 512, budget 300 and the default c.
// If the receiver stalls, the finished result waits in the output register, the
// engine holds its next result, the two-entry queue fills, the front end holds one
// more pixel and full stays high.
`default_nettype none

module julia_escape_time_pixel #(
	parameter int COORD_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [COORD_BITS-1:0] pixel_x,
	input wire logic [COORD_BITS-1:0] pixel_y,
	input wire logic cfg_we,
	input wire logic [jetp_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [jetp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic empty,
	input wire logic pop,
	output logic status,
	output logic [jetp_pkg::ITER_W-1:0] iterations_left,
	output logic in_set
);

	localparam int QUEUE_DEPTH = 2;
	localparam int JOB_W = $bits(jetp_pkg::job_t);

	logic [jetp_pkg::DIM_W-1:0] image_width_q;
	logic [jetp_pkg::DIM_W-1:0] image_height_q;
	logic [jetp_pkg::ITER_W-1:0] max_iter_q;
	logic [jetp_pkg::CREG_W-1:0] c_real_q;
	logic [jetp_pkg::CREG_W-1:0] c_imag_q;

	logic fr_valid;
	logic q_full;
	logic q_empty;
	logic q_pop;
	jetp_pkg::job_t fr_job;
	jetp_pkg::job_t bk_job;
	logic [JOB_W-1:0] q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= jetp_pkg::IMAGE_WIDTH_RST;
			image_height_q <= jetp_pkg::IMAGE_HEIGHT_RST;
			max_iter_q <= jetp_pkg::MAX_ITER_RST;
			c_real_q <= jetp_pkg::C_REAL_RST;
			c_imag_q <= jetp_pkg::C_IMAG_RST;
		end else if (cfg_we) begin
			unique case (jetp_pkg::cfg_idx_t'(cfg_index))
				jetp_pkg::CFG_IMAGE_WIDTH: image_width_q <= cfg_data[jetp_pkg::DIM_W-1:0];
				jetp_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[jetp_pkg::DIM_W-1:0];
				jetp_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data[jetp_pkg::ITER_W-1:0];
				jetp_pkg::CFG_C_REAL: c_real_q <= cfg_data[jetp_pkg::CREG_W-1:0];
				jetp_pkg::CFG_C_IMAG: c_imag_q <= cfg_data[jetp_pkg::CREG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	jetp_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.image_width(image_width_q),
		.image_height(image_height_q),
		.job_valid(fr_valid),
		.job_ready(!q_full),
		.job(fr_job)
	);

	jetp_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(fr_valid),
		.wr_data(fr_job),
		.full(q_full),
		.rd_en(q_pop),
		.rd_data(q_rd_data),
		.empty(q_empty)
	);

	assign bk_job = jetp_pkg::job_t'(q_rd_data);

	jetp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(!q_empty),
		.job(bk_job),
		.job_pop(q_pop),
		.max_iterations(max_iter_q),
		.c_real(c_real_q),
		.c_imag(c_imag_q),
		.empty(empty),
		.pop(pop),
		.status(status),
		.iterations_left(iterations_left),
		.in_set(in_set)
	);

endmodule

`default_nettype wire
